// ----- hdl/minimax_alpha_beta_binary_tree_defines.svh -----
// Assertion macros for the checker of the alpha-beta search block.
`ifndef MINIMAX_ALPHA_BETA_BINARY_TREE_DEFINES_SVH
`define MINIMAX_ALPHA_BETA_BINARY_TREE_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define MABT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MABT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mabt_pkg.sv -----
// Shared constants, codes and types of the alpha-beta search block.
`default_nettype none

package mabt_pkg;

  // Default sizes of the tree and of the stored scores.
  localparam int MAX_DEPTH_DEF  = 8;
  localparam int SCORE_BITS_DEF = 16;

  // Fixed widths of the stream fields.
  localparam int INDEX_W    = 8;
  localparam int SCORE_W    = 16;
  localparam int VISIT_W    = 9;
  localparam int DEPTH_W    = 4;
  localparam int IN_DATA_W  = INDEX_W + SCORE_W;
  localparam int OUT_DATA_W = ((SCORE_W + VISIT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - SCORE_W - VISIT_W;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd4;
  localparam logic [VISIT_W-1:0] VISIT_MAX   = '1;

  // Operation carried in the input word's tuser.
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  // Search sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DESCEND,
    ST_LEAF,
    ST_UPDATE,
    ST_TEST,
    ST_DONE
  } eng_state_t;

  // One search result.
  typedef struct packed {
    logic signed [SCORE_W-1:0] root_value;
    logic [VISIT_W-1:0]        leaves_visited;
  } result_t;

  // Status that the search engine reports to the stream side.
  typedef struct packed {
    logic    idle;
    logic    done;
    result_t result;
  } eng_status_t;

endpackage

`default_nettype wire

// ----- hdl/mabt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mabt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mabt_cmp.sv -----
// Shared signed less-than unit used for every score comparison.
`default_nettype none

module mabt_cmp #(
  parameter int WIDTH = 17
) (
  input  wire logic signed [WIDTH-1:0] a,
  input  wire logic signed [WIDTH-1:0] b,
  output logic                         lt
);

  // Signed compare of the two selected scores.
  assign lt = (a < b);

endmodule

`default_nettype wire

// ----- hdl/mabt_engine.sv -----
// Alpha-beta search sequencer with its window and child stacks.
`default_nettype none

module mabt_engine import mabt_pkg::*; #(
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [DEPTH_W-1:0]           depth,
  input  wire logic                         take,
  output logic                              rd_en,
  output logic      [MAX_DEPTH-1:0]         rd_addr,
  input  wire logic signed [SCORE_BITS-1:0] rd_data,
  output eng_status_t                       status
);

  localparam int VW      = SCORE_BITS + 1;
  localparam int LW      = $clog2(MAX_DEPTH + 1);
  localparam int STACK_N = MAX_DEPTH + 1;

  // Window bound just above every leaf magnitude: 2^(SCORE_BITS-1) + 1.
  localparam logic signed [VW-1:0] POS_INF = {2'b01, {(SCORE_BITS - 2){1'b0}}, 1'b1};
  localparam logic signed [VW-1:0] NEG_INF = -POS_INF;

  eng_state_t state, state_next;

  logic [LW-1:0]          lvl;
  logic [LW-1:0]          d_lim;
  logic [LW-1:0]          d_sat;
  logic [LW-1:0]          lvl_inc;
  logic [LW-1:0]          rd_idx;
  logic [MAX_DEPTH-1:0]   node;
  logic signed [VW-1:0]   v;
  logic [VISIT_W-1:0]     visits;

  logic signed [VW-1:0]   alpha_stk [STACK_N];
  logic signed [VW-1:0]   beta_stk  [STACK_N];
  logic [STACK_N-1:0]     child_stk;

  logic signed [VW-1:0]   alpha_rd;
  logic signed [VW-1:0]   beta_rd;
  logic                   child_rd;
  logic                   max_lvl;
  logic                   at_leaf;
  logic signed [VW-1:0]   cmp_a;
  logic signed [VW-1:0]   cmp_b;
  logic                   cmp_lt;
  logic                   stop;

  // Stack read address: the parent level while updating, otherwise the current one.
  always_comb begin
    lvl_inc = lvl + LW'(1);
    if (state == ST_UPDATE && lvl != '0) begin
      rd_idx = lvl - LW'(1);
    end else begin
      rd_idx = lvl;
    end
    alpha_rd = alpha_stk[rd_idx];
    beta_rd  = beta_stk[rd_idx];
    child_rd = child_stk[rd_idx];
    max_lvl  = ~rd_idx[0];
    at_leaf  = (lvl == d_lim);
    if (int'(depth) > MAX_DEPTH) begin
      d_sat = LW'(MAX_DEPTH);
    end else begin
      d_sat = LW'(depth);
    end
  end

  // Operand selection for the shared comparator.
  always_comb begin
    if (state == ST_UPDATE) begin
      if (max_lvl) begin
        cmp_a = alpha_rd;
        cmp_b = v;
      end else begin
        cmp_a = v;
        cmp_b = beta_rd;
      end
    end else begin
      cmp_a = alpha_rd;
      cmp_b = beta_rd;
    end
  end

  mabt_cmp #(
    .WIDTH (VW)
  ) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  // A level is finished on a cutoff (beta <= alpha) or after its second child.
  assign stop = !cmp_lt || child_rd;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DESCEND;
        end
      end
      ST_DESCEND: begin
        if (at_leaf) begin
          state_next = ST_LEAF;
        end
      end
      ST_LEAF: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (lvl == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        if (stop) begin
          state_next = ST_UPDATE;
        end else begin
          state_next = ST_DESCEND;
        end
      end
      ST_DONE: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    rd_en                        = (state == ST_DESCEND) && at_leaf;
    rd_addr                      = node;
    status.idle                  = (state == ST_IDLE);
    status.done                  = (state == ST_DONE);
    status.result.root_value     = SCORE_W'(v);
    status.result.leaves_visited = visits;
  end

  // Control registers: state, level pointer, depth limit and leaf count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      lvl    <= '0;
      d_lim  <= '0;
      visits <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (start) begin
            lvl    <= '0;
            d_lim  <= d_sat;
            visits <= '0;
          end
        end
        ST_DESCEND: begin
          if (!at_leaf) begin
            lvl <= lvl_inc;
          end
        end
        ST_LEAF: begin
          if (visits != VISIT_MAX) begin
            visits <= visits + VISIT_W'(1);
          end
        end
        ST_UPDATE: begin
          if (lvl != '0) begin
            lvl <= rd_idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath: path bits, current value and the per-level stacks.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          node         <= '0;
          alpha_stk[0] <= NEG_INF;
          beta_stk[0]  <= POS_INF;
          child_stk[0] <= 1'b0;
        end
      end
      ST_DESCEND: begin
        if (!at_leaf) begin
          alpha_stk[lvl_inc] <= alpha_rd;
          beta_stk[lvl_inc]  <= beta_rd;
          child_stk[lvl_inc] <= 1'b0;
          node               <= MAX_DEPTH'({node, child_rd});
        end
      end
      ST_LEAF: begin
        v <= VW'(rd_data);
      end
      ST_UPDATE: begin
        if (lvl != '0) begin
          node <= node >> 1;
          if (cmp_lt) begin
            if (max_lvl) begin
              alpha_stk[rd_idx] <= v;
            end else begin
              beta_stk[rd_idx] <= v;
            end
          end
        end
      end
      ST_TEST: begin
        if (stop) begin
          v <= max_lvl ? alpha_rd : beta_rd;
        end else begin
          child_stk[rd_idx] <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/minimax_alpha_beta_binary_tree.sv -----
// Top level of the alpha-beta search block: stream ports, leaf store and result register.
//
// Leaf scores are loaded one word per cycle, while no search runs, into a leaf store of
// 2^MAX_DEPTH entries; a search word then walks the tree of tree_depth levels (saturated
// at MAX_DEPTH) with minimax and alpha-beta pruning and returns one result word holding
// the root value and the number of leaves evaluated. A search starts, descends level by
// level, reads each leaf from the registered leaf store and, on each level climbed, uses
// the one shared comparator first to update the window and then to test for a cutoff,
// before it hands over the result. The input stays not ready for the whole search; a
// finished result waits in the output register while new loads are taken. The leaf
// store is not cleared at reset: search only leaves that were loaded.
`default_nettype none

module minimax_alpha_beta_binary_tree import mabt_pkg::*; #(
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [DEPTH_W-1:0]    cfg_wr_data,   // tree_depth
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // leaf_index[7:0], leaf_score[23:8]
  input  wire logic                  s_axis_tuser,  // operation[0]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata   // root_value[15:0], leaves_visited[24:16]
);

  logic [DEPTH_W-1:0]           tree_depth;
  logic                         in_accept;
  op_t                          in_op;
  logic [INDEX_W-1:0]           leaf_index;
  logic signed [SCORE_W-1:0]    leaf_score;
  logic                         store_wr_en;
  logic [MAX_DEPTH-1:0]         store_wr_addr;
  logic signed [SCORE_BITS-1:0] store_wr_data;
  logic                         store_rd_en;
  logic [MAX_DEPTH-1:0]         store_rd_addr;
  logic signed [SCORE_BITS-1:0] store_rd_data;
  logic                         search_start;
  logic                         take;
  eng_status_t                  eng_status;
  logic                         out_valid;
  result_t                      out_res;

  // Depth register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_depth <= DEPTH_RESET;
    end else if (cfg_wr_en) begin
      tree_depth <= cfg_wr_data;
    end
  end

  // Input word decode.
  always_comb begin
    in_accept     = s_axis_tvalid && s_axis_tready;
    in_op         = op_t'(s_axis_tuser);
    leaf_index    = s_axis_tdata[INDEX_W-1:0];
    leaf_score    = s_axis_tdata[INDEX_W +: SCORE_W];
    store_wr_en   = in_accept && (in_op == OP_LOAD);
    store_wr_addr = MAX_DEPTH'(leaf_index);
    store_wr_data = SCORE_BITS'(leaf_score);
    search_start  = in_accept && (in_op == OP_SEARCH);
    s_axis_tready = eng_status.idle;
  end

  mabt_ram #(
    .WIDTH (SCORE_BITS),
    .DEPTH (2 ** MAX_DEPTH)
  ) u_leaf_store (
    .clk     (clk),
    .wr_en   (store_wr_en),
    .wr_addr (store_wr_addr),
    .wr_data (store_wr_data),
    .rd_en   (store_rd_en),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd_data)
  );

  mabt_engine #(
    .MAX_DEPTH  (MAX_DEPTH),
    .SCORE_BITS (SCORE_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (search_start),
    .depth   (tree_depth),
    .take    (take),
    .rd_en   (store_rd_en),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd_data),
    .status  (eng_status)
  );

  // The result moves to the output register once that register is free.
  assign take = eng_status.done && (!out_valid || m_axis_tready);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= eng_status.result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_res.leaves_visited, out_res.root_value};

endmodule

`default_nettype wire

// ----- hdl/mabt_checker.sv -----
// Port-level checks of the alpha-beta search block, bound to its top level.
`include "minimax_alpha_beta_binary_tree_defines.svh"
`default_nettype none

module mabt_checker import mabt_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A stalled result word keeps its contents.
  `MABT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // An accepted search makes the input side busy in the next cycle.
  `MABT_ASSERT(a_search_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready, "input still ready after search start")

  // A leaf load leaves the input side ready.
  `MABT_ASSERT(a_load_ready, s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready, "input not ready after leaf load")

  // Every search evaluates at least one leaf.
  `MABT_ASSERT(a_visits_nonzero, m_axis_tvalid |-> m_axis_tdata[SCORE_W +: VISIT_W] != '0, "result reports no leaf evaluated")

  // Reset empties the output register.
  `MABT_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "result word valid after reset")

endmodule

bind minimax_alpha_beta_binary_tree mabt_checker u_mabt_checker (.*);

`default_nettype wire
